@@ hdl/qdse_pkg.sv @@
`timescale 1ns / 1ps
package qdse_pkg;

  localparam int CFG_WIDTH       = 13;
  localparam int CFG_INDEX_WIDTH = 2;

  // The result queue depth must be a power of two so that its pointers wrap on their own.
  localparam int QUEUE_DEPTH = 4;

  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_CHAR  = 2'd1;
  localparam logic [1:0] KIND_DRAIN = 2'd2;

  localparam logic [1:0] MODE_NUMERIC = 2'd0;
  localparam logic [1:0] MODE_ALNUM   = 2'd1;
  localparam logic [1:0] MODE_BYTE    = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_CHAR = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_MODE    = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_VERSION = 2'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_LEVEL   = 2'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_COUNT   = 2'd3;

  localparam logic [7:0] PAD_FIRST  = 8'hEC;
  localparam logic [7:0] PAD_SECOND = 8'h11;
  localparam logic [5:0] ALNUM_BASE = 6'd45;
  localparam logic [2:0] TERM_BITS  = 3'd4;

  localparam logic [5:0] VERSION_MIN = 6'd1;
  localparam logic [5:0] VERSION_MAX = 6'd40;

  typedef struct packed {
    logic [1:0]  encoding_mode;
    logic [5:0]  symbol_version;
    logic [1:0]  correction_level;
    logic [12:0] char_count;
  } cfg_t;

  typedef struct packed {
    logic [7:0] codeword;
    logic       last_codeword;
    logic [1:0] status;
  } result_t;

  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

  typedef struct packed {
    logic       ok;
    logic [5:0] value;
  } alnum_t;

  // Data codewords per version (rows) and correction level L, M, Q, H (columns).
  localparam logic [11:0] CAP_TABLE [160] = '{
    19, 16, 13, 9,        34, 28, 22, 16,        55, 44, 34, 26,        80, 64, 48, 36,
    108, 86, 62, 46,      136, 108, 76, 60,      156, 124, 88, 66,      194, 154, 110, 86,
    232, 182, 132, 100,   274, 216, 154, 122,    324, 254, 180, 140,    370, 290, 206, 158,
    428, 334, 244, 180,   461, 365, 261, 197,    523, 415, 295, 223,    589, 453, 325, 253,
    647, 507, 367, 283,   721, 563, 397, 313,    795, 627, 445, 341,    861, 669, 485, 385,
    932, 714, 512, 406,   1006, 782, 568, 442,   1094, 860, 614, 464,   1174, 914, 664, 514,
    1276, 1000, 718, 538, 1370, 1062, 754, 596,  1468, 1128, 808, 628,  1531, 1193, 871, 661,
    1631, 1267, 911, 701, 1735, 1373, 985, 745,  1843, 1455, 1033, 793, 1955, 1541, 1115, 845,
    2071, 1631, 1171, 901, 2191, 1725, 1231, 961, 2306, 1812, 1286, 986,
    2434, 1914, 1354, 1054,
    2566, 1992, 1426, 1096, 2702, 2102, 1502, 1142, 2812, 2216, 1582, 1222,
    2956, 2334, 1666, 1276
  };

  function automatic logic [4:0] count_width(input logic [1:0] mode, input logic [5:0] ver);
    logic [4:0] w;
    if (mode == MODE_NUMERIC) begin
      w = (ver <= 6'd9) ? 5'd10 : ((ver <= 6'd26) ? 5'd12 : 5'd14);
    end else if (mode == MODE_ALNUM) begin
      w = (ver <= 6'd9) ? 5'd9 : ((ver <= 6'd26) ? 5'd11 : 5'd13);
    end else begin
      w = (ver <= 6'd9) ? 5'd8 : 5'd16;
    end
    return w;
  endfunction

  function automatic alnum_t alnum_decode(input logic [7:0] c);
    alnum_t a;
    a.ok    = 1'b1;
    a.value = '0;
    priority if (c >= 8'h30 && c <= 8'h39) begin
      a.value = 6'(c - 8'h30);
    end else if (c >= 8'h41 && c <= 8'h5A) begin
      a.value = 6'(c - 8'd55);
    end else begin
      unique case (c)
        8'h20:   a.value = 6'd36;
        8'h24:   a.value = 6'd37;
        8'h25:   a.value = 6'd38;
        8'h2A:   a.value = 6'd39;
        8'h2B:   a.value = 6'd40;
        8'h2D:   a.value = 6'd41;
        8'h2E:   a.value = 6'd42;
        8'h2F:   a.value = 6'd43;
        8'h3A:   a.value = 6'd44;
        default: a.ok = 1'b0;
      endcase
    end
    return a;
  endfunction

endpackage

@@ hdl/qdse_if.sv @@
`timescale 1ns / 1ps
interface qdse_item_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] char_code;

  modport source (output valid, output kind, output char_code, input ready);
  modport sink (input valid, input kind, input char_code, output ready);
endinterface

interface qdse_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] codeword;
  logic       last_codeword;
  logic [1:0] status;

  modport source (output valid, output codeword, output last_codeword, output status,
                  input ready);
  modport sink (input valid, input codeword, input last_codeword, input status,
                output ready);
endinterface

@@ hdl/qdse_queue.sv @@
`timescale 1ns / 1ps
module qdse_queue import qdse_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  push_t   push,
  output logic    room,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  localparam int PtrW = $clog2(QUEUE_DEPTH);
  localparam int CntW = PtrW + 1;

  result_t         mem [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] wr_ptr_b;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count != '0);
  assign out_data  = mem[rd_ptr];
  assign wr_ptr_b  = wr_ptr + 1'b1;
  // Room for the largest burst a request can produce.
  assign room      = (count <= CntW'(QUEUE_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PtrW'(push.count);
      rd_ptr <= rd_ptr + PtrW'(pop);
      count  <= count + CntW'(push.count) - CntW'(pop);
    end
    if (push.count != 2'd0) begin
      mem[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      mem[wr_ptr_b] <= push.second;
    end
  end

endmodule

@@ hdl/qdse_core.sv @@
`timescale 1ns / 1ps
module qdse_core import qdse_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       item_valid,
  output logic       item_ready,
  input  logic [1:0] item_kind,
  input  logic [7:0] item_char,
  input  logic       room,
  output push_t      push
);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_DATA,
    PH_PAD
  } phase_t;

  logic       held;
  logic [1:0] held_kind;
  logic [7:0] held_char;
  logic       fire;

  logic [6:0]  acc, acc_next;
  logic [2:0]  pend, pend_next;
  logic [6:0]  gval, gval_next;
  logic [1:0]  gfill, gfill_next;
  logic [12:0] seen, seen_next;
  logic [11:0] bytes_out, bytes_next;
  logic [11:0] cap, cap_next;
  phase_t      phase, phase_next;
  logic [1:0]  seg_mode, mode_next;
  logic        pad_tog, tog_next;

  logic [5:0]  ver_sat;
  logic [1:0]  mode_eff;
  logic [4:0]  cw;
  logic [11:0] cap_sel;
  logic [16:0] mask_wide;
  logic [15:0] count_mask;
  logic        count_ok;
  logic [3:0]  indicator;

  logic        is_digit;
  logic [3:0]  digit;
  logic [9:0]  num_full;
  logic [6:0]  num_part;
  alnum_t      av;
  logic [10:0] alnum_full;
  logic [12:0] seen_inc;

  logic [11:0] room_bytes;
  logic [3:0]  tail_bits;
  logic [2:0]  term;
  logic [4:0]  used;
  logic [4:0]  padded;

  logic [23:0] put_val;
  logic [4:0]  put_len;
  logic [6:0]  base_acc;
  logic [2:0]  base_pend;
  logic [23:0] word;
  logic [4:0]  total;
  logic [1:0]  nbytes;
  logic [7:0]  byte0, byte1;
  logic [4:0]  rest;
  logic [11:0] cnt_base, cap_base, cnt1, cnt2;
  logic [1:0]  emit_st;
  result_t     r0, r1, pad_res;
  logic        pack_en, err_en, pad_en;
  logic [1:0]  err_st;

  assign fire       = held && room;
  assign item_ready = !held || fire;

  assign ver_sat    = (cfg.symbol_version < VERSION_MIN) ? VERSION_MIN :
                      ((cfg.symbol_version > VERSION_MAX) ? VERSION_MAX : cfg.symbol_version);
  assign mode_eff   = (cfg.encoding_mode > MODE_BYTE) ? MODE_BYTE : cfg.encoding_mode;
  assign cw         = count_width(mode_eff, ver_sat);
  assign cap_sel    = CAP_TABLE[{6'(ver_sat - VERSION_MIN), cfg.correction_level}];
  assign mask_wide  = (17'd1 << cw) - 17'd1;
  assign count_mask = mask_wide[15:0];
  assign count_ok   = (({3'b000, cfg.char_count} & ~count_mask) == 16'd0);
  assign indicator  = 4'b0001 << mode_eff;

  assign is_digit   = (held_char >= 8'h30) && (held_char <= 8'h39);
  assign digit      = 4'(held_char - 8'h30);
  assign num_full   = 10'(gval) * 10'd10 + 10'(digit);
  assign num_part   = num_full[6:0];
  assign av         = alnum_decode(held_char);
  assign alnum_full = 11'(gval) * 11'(ALNUM_BASE) + 11'(av.value);
  assign seen_inc   = seen + 13'd1;

  assign room_bytes = cap - bytes_out;
  assign tail_bits  = 4'd8 - 4'(pend);
  assign term       = (room_bytes == 12'd0) ? 3'd0 :
                      ((room_bytes == 12'd1 && tail_bits < 4'(TERM_BITS)) ? tail_bits[2:0]
                                                                          : TERM_BITS);
  assign used       = 5'(pend) + 5'(term);
  assign padded     = (used + 5'd7) & 5'b11000;

  always_comb begin
    acc_next   = acc;
    pend_next  = pend;
    gval_next  = gval;
    gfill_next = gfill;
    seen_next  = seen;
    bytes_next = bytes_out;
    cap_next   = cap;
    phase_next = phase;
    mode_next  = seg_mode;
    tog_next   = pad_tog;
    base_acc   = acc;
    base_pend  = pend;
    put_val    = '0;
    put_len    = '0;
    cnt_base   = bytes_out;
    cap_base   = cap;
    emit_st    = ST_OK;
    pack_en    = 1'b0;
    err_en     = 1'b0;
    err_st     = ST_OK;
    pad_en     = 1'b0;

    unique case (held_kind)
      KIND_START: begin
        mode_next  = mode_eff;
        cap_next   = cap_sel;
        gval_next  = '0;
        gfill_next = '0;
        seen_next  = '0;
        tog_next   = 1'b0;
        phase_next = PH_DATA;
        base_acc   = '0;
        base_pend  = '0;
        cnt_base   = '0;
        cap_base   = cap_sel;
        put_val    = (24'(indicator) << cw) | 24'({3'b000, cfg.char_count} & count_mask);
        put_len    = 5'd4 + cw;
        emit_st    = count_ok ? ST_OK : ST_OVERFLOW;
        pack_en    = 1'b1;
      end
      KIND_CHAR: begin
        if (phase == PH_DATA) begin
          if (seen >= cfg.char_count) begin
            err_en = 1'b1;
            err_st = ST_OVERFLOW;
          end else begin
            unique case (seg_mode)
              MODE_NUMERIC: begin
                if (!is_digit) begin
                  err_en = 1'b1;
                  err_st = ST_BAD_CHAR;
                end else begin
                  pack_en   = 1'b1;
                  seen_next = seen_inc;
                  if (gfill == 2'd2) begin
                    put_val    = 24'(num_full);
                    put_len    = 5'd10;
                    gval_next  = '0;
                    gfill_next = '0;
                  end else if (seen_inc == cfg.char_count) begin
                    put_val    = 24'(num_part);
                    put_len    = (gfill == 2'd1) ? 5'd7 : 5'd4;
                    gval_next  = '0;
                    gfill_next = '0;
                  end else begin
                    gval_next  = num_part;
                    gfill_next = gfill + 2'd1;
                  end
                end
              end
              MODE_ALNUM: begin
                if (!av.ok) begin
                  err_en = 1'b1;
                  err_st = ST_BAD_CHAR;
                end else begin
                  pack_en   = 1'b1;
                  seen_next = seen_inc;
                  if (gfill == 2'd1) begin
                    put_val    = 24'(alnum_full);
                    put_len    = 5'd11;
                    gval_next  = '0;
                    gfill_next = '0;
                  end else if (seen_inc == cfg.char_count) begin
                    put_val    = 24'(av.value);
                    put_len    = 5'd6;
                    gval_next  = '0;
                    gfill_next = '0;
                  end else begin
                    gval_next  = 7'(av.value);
                    gfill_next = 2'd1;
                  end
                end
              end
              default: begin
                pack_en   = 1'b1;
                seen_next = seen_inc;
                put_val   = 24'(held_char);
                put_len   = 5'd8;
              end
            endcase
          end
        end
      end
      KIND_DRAIN: begin
        if (phase == PH_DATA) begin
          // Terminator and zero fill up to the next byte boundary.
          phase_next = PH_PAD;
          gval_next  = '0;
          gfill_next = '0;
          put_len    = padded - 5'(pend);
          pack_en    = 1'b1;
        end else if (phase == PH_PAD && bytes_out < cap) begin
          pad_en = 1'b1;
        end
      end
      default: begin
      end
    endcase

    word   = (24'(base_acc) << put_len) | put_val;
    total  = 5'(base_pend) + put_len;
    nbytes = (total >= 5'd16) ? 2'd2 : ((total >= 5'd8) ? 2'd1 : 2'd0);
    byte0  = 8'(word >> (total - 5'd8));
    byte1  = 8'(word >> (total - 5'd16));
    rest   = total - {nbytes, 3'b000};

    if (cnt_base < cap_base) begin
      r0   = '{codeword: byte0, last_codeword: (cnt_base + 12'd1 == cap_base), status: emit_st};
      cnt1 = cnt_base + 12'd1;
    end else begin
      r0   = '{codeword: 8'd0, last_codeword: 1'b0, status: ST_OVERFLOW};
      cnt1 = cnt_base;
    end
    if (cnt1 < cap_base) begin
      r1   = '{codeword: byte1, last_codeword: (cnt1 + 12'd1 == cap_base), status: emit_st};
      cnt2 = cnt1 + 12'd1;
    end else begin
      r1   = '{codeword: 8'd0, last_codeword: 1'b0, status: ST_OVERFLOW};
      cnt2 = cnt1;
    end

    pad_res = '{codeword: (pad_tog ? PAD_SECOND : PAD_FIRST),
                last_codeword: (bytes_out + 12'd1 == cap), status: ST_OK};

    if (pack_en) begin
      acc_next   = word[6:0] & 7'((8'd1 << rest[2:0]) - 8'd1);
      pend_next  = rest[2:0];
      bytes_next = (nbytes == 2'd0) ? cnt_base : ((nbytes == 2'd1) ? cnt1 : cnt2);
    end
    if (pad_en) begin
      bytes_next = bytes_out + 12'd1;
      tog_next   = ~pad_tog;
    end

    push = '0;
    if (fire) begin
      priority if (pack_en) begin
        push.count  = nbytes;
        push.first  = r0;
        push.second = r1;
      end else if (err_en) begin
        push.count = 2'd1;
        push.first = '{codeword: 8'd0, last_codeword: 1'b0, status: err_st};
      end else if (pad_en) begin
        push.count = 2'd1;
        push.first = pad_res;
      end else begin
        push.count = 2'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held      <= 1'b0;
      acc       <= '0;
      pend      <= '0;
      gval      <= '0;
      gfill     <= '0;
      seen      <= '0;
      bytes_out <= '0;
      cap       <= '0;
      phase     <= PH_IDLE;
      seg_mode  <= MODE_BYTE;
      pad_tog   <= 1'b0;
    end else begin
      if (item_ready) begin
        held <= item_valid;
      end
      if (fire) begin
        acc       <= acc_next;
        pend      <= pend_next;
        gval      <= gval_next;
        gfill     <= gfill_next;
        seen      <= seen_next;
        bytes_out <= bytes_next;
        cap       <= cap_next;
        phase     <= phase_next;
        seg_mode  <= mode_next;
        pad_tog   <= tog_next;
      end
    end
    if (item_valid && item_ready) begin
      held_kind <= item_kind;
      held_char <= item_char;
    end
  end

endmodule

@@ hdl/qr_data_segment_encoder.sv @@
// Flow: a request is held in the input register, and its codewords are then written into the
// result queue, from which the first is offered; a full queue keeps the request in the register.
// Throughput: one request per cycle while each request yields at most one codeword and the queue
// has room; a two-codeword request is paced by the one-codeword-per-cycle result queue.
// Reset: synchronous active-high rst empties the result queue, clears the segment state and
// returns the configuration to byte mode, version 1, level L and a count of zero.
`timescale 1ns / 1ps
module qr_data_segment_encoder import qdse_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [CFG_WIDTH-1:0]       cfg_data,
  qdse_item_if.sink                  items,
  qdse_result_if.source              results
);

  cfg_t    cfg;
  push_t   push;
  logic    room;
  result_t head;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{encoding_mode: MODE_BYTE, symbol_version: VERSION_MIN,
               correction_level: 2'd0, char_count: 13'd0};
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MODE:    cfg.encoding_mode    <= cfg_data[1:0];
        CFG_VERSION: cfg.symbol_version   <= cfg_data[5:0];
        CFG_LEVEL:   cfg.correction_level <= cfg_data[1:0];
        CFG_COUNT:   cfg.char_count       <= cfg_data[12:0];
        default: begin
        end
      endcase
    end
  end

  qdse_core u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (items.valid),
    .item_ready (items.ready),
    .item_kind  (items.kind),
    .item_char  (items.char_code),
    .room       (room),
    .push       (push)
  );

  qdse_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .out_data  (head)
  );

  assign results.codeword      = head.codeword;
  assign results.last_codeword = head.last_codeword;
  assign results.status        = head.status;

endmodule

@@ hdl/qdse_checker.sv @@
`timescale 1ns / 1ps
module qdse_checker import qdse_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       res_valid,
  input logic       res_ready,
  input logic [7:0] codeword,
  input logic       last_codeword,
  input logic [1:0] status
);

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable({codeword, last_codeword, status}))
    else $error("Stalled result changed or was withdrawn.");

  a_bad_char_empty: assert property (@(posedge clk) disable iff (rst)
    res_valid && status == ST_BAD_CHAR |-> codeword == 8'd0 && !last_codeword)
    else $error("Invalid-character result carries data.");

  a_last_is_ok: assert property (@(posedge clk) disable iff (rst)
    res_valid && last_codeword |-> status == ST_OK)
    else $error("Final codeword flagged with an error status.");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !res_valid)
    else $error("Result offered right after reset.");

endmodule

bind qr_data_segment_encoder qdse_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .res_valid     (results.valid),
  .res_ready     (results.ready),
  .codeword      (results.codeword),
  .last_codeword (results.last_codeword),
  .status        (results.status)
);
